// ----- hw/rtl/rmrh_pkg.sv -----
// Shared types, constants and helpers for the ray march / rectangle hit block.
// No dependencies; imported by rmrh_rect_scan, ray_march_rect_hit and the bench.
`timescale 1ns / 1ps
`default_nettype none

package rmrh_pkg;

   localparam int MAX_RECTS  = 16;
   localparam int FRAC_BITS  = 6;

   localparam int POS_W      = 16;
   localparam int DIR_W      = 8;
   localparam int EXT_W      = 15;
   localparam int COLOR_W    = 24;
   localparam int DIST_W     = 24;
   localparam int LEN_W      = 16;
   localparam int BOUND_W    = 9;
   localparam int COUNT_W    = 5;
   localparam int IDX_IN_W   = 4;
   localparam int PIX_W      = 10;
   localparam int CMD_W      = 2;
   localparam int REG_W      = 2;
   localparam int CSR_DATA_W = 24;

   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 48;

   localparam int RECT_IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int SCAN_CNT_W = $clog2(MAX_RECTS + 1);

   localparam int PIX_MAX    = (1 << (PIX_W - 1)) - 1;
   localparam int PIX_MIN    = -(1 << (PIX_W - 1));

   localparam logic [BOUND_W-1:0] BOUND_X_RST    = BOUND_W'(400);
   localparam logic [BOUND_W-1:0] BOUND_Y_RST    = BOUND_W'(300);
   localparam logic [COLOR_W-1:0] PATH_COLOR_RST = COLOR_W'(24'h505050);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_STEP  = 2'd2
   } rmrh_cmd_type;

   typedef enum logic [REG_W-1:0] {
      REG_BOUND_X    = 2'd0,
      REG_BOUND_Y    = 2'd1,
      REG_PATH_COLOR = 2'd2,
      REG_RECT_COUNT = 2'd3
   } rmrh_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PATH,
      ST_FINAL
   } rmrh_state_type;

   typedef struct packed {
      logic [EXT_W-1:0]        ext_y;
      logic [EXT_W-1:0]        ext_x;
      logic signed [POS_W-1:0] top;
      logic signed [POS_W-1:0] left;
   } rmrh_rect_type;

   typedef struct packed {
      logic                  go;
      logic [SCAN_CNT_W-1:0] count;
   } rmrh_scan_req_type;

   typedef struct packed {
      logic               done;
      logic               hit;
      logic [COLOR_W-1:0] color;
   } rmrh_scan_rsp_type;

   // Clamp a one-bit-wider sum back into the signed position range.
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
      if (v[POS_W] != v[POS_W-1]) begin
         return v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end
      return v[POS_W-1:0];
   endfunction

   // Negate a direction; the most negative code maps to the most positive.
   function automatic logic signed [DIR_W-1:0] negate_dir(input logic signed [DIR_W-1:0] v);
      if (v == {1'b1, {(DIR_W-1){1'b0}}}) begin
         return {1'b0, {(DIR_W-1){1'b1}}};
      end
      return -v;
   endfunction

   // Floor of a fixed-point position, clamped to the pixel range.
   function automatic logic signed [PIX_W-1:0] pixel_of(input logic signed [POS_W-1:0] p);
      logic signed [POS_W-1:0] q;
      q = p >>> FRAC_BITS;
      if (int'(q) > PIX_MAX) begin
         return PIX_W'(PIX_MAX);
      end
      if (int'(q) < PIX_MIN) begin
         return PIX_W'(PIX_MIN);
      end
      return PIX_W'(q);
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rmrh_rect_scan.sv -----
// Rectangle table and the shared hit test, walked one entry per cycle.
// Depends on rmrh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmrh_rect_scan (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              load_en,
   input  wire logic [rmrh_pkg::RECT_IDX_W-1:0]   load_idx,
   input  wire rmrh_pkg::rmrh_rect_type           load_rect,
   input  wire logic [rmrh_pkg::COLOR_W-1:0]      load_color,
   input  wire rmrh_pkg::rmrh_scan_req_type       scan_req,
   input  wire logic signed [rmrh_pkg::POS_W-1:0] pos_x,
   input  wire logic signed [rmrh_pkg::POS_W-1:0] pos_y,
   output rmrh_pkg::rmrh_scan_rsp_type            scan_rsp
);
   import rmrh_pkg::*;

   rmrh_rect_type      geo_mem   [MAX_RECTS];
   logic [COLOR_W-1:0] color_mem [MAX_RECTS];

   rmrh_rect_type         rd_geo_ff;
   logic [COLOR_W-1:0]    rd_color_ff;
   logic                  running_ff;
   logic                  chk_vld_ff;
   logic [SCAN_CNT_W-1:0] issue_ff;
   logic [SCAN_CNT_W-1:0] count_ff;
   logic                  done_ff;
   logic                  hit_ff;
   logic [COLOR_W-1:0]    color_ff;

   logic                    rd_en;
   logic signed [POS_W:0]   right_edge;
   logic signed [POS_W:0]   bottom_edge;
   logic                    inside_now;
   logic                    hit_now;

   assign rd_en = running_ff && (issue_ff < count_ff);

   assign right_edge  = (POS_W+1)'(rd_geo_ff.left) + signed'((POS_W+1)'(rd_geo_ff.ext_x));
   assign bottom_edge = (POS_W+1)'(rd_geo_ff.top) + signed'((POS_W+1)'(rd_geo_ff.ext_y));

   // Open interior: every edge is exclusive.
   assign inside_now = (pos_x > rd_geo_ff.left) && ((POS_W+1)'(pos_x) < right_edge) &&
                       (pos_y > rd_geo_ff.top)  && ((POS_W+1)'(pos_y) < bottom_edge);
   assign hit_now    = chk_vld_ff && inside_now;

   always_ff @(posedge clock) begin
      if (load_en) begin
         geo_mem[load_idx]   <= load_rect;
         color_mem[load_idx] <= load_color;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_geo_ff   <= geo_mem[issue_ff[RECT_IDX_W-1:0]];
         rd_color_ff <= color_mem[issue_ff[RECT_IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         chk_vld_ff <= 1'b0;
         issue_ff   <= '0;
         count_ff   <= '0;
         done_ff    <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (scan_req.go) begin
            running_ff <= 1'b1;
            chk_vld_ff <= 1'b0;
            issue_ff   <= '0;
            count_ff   <= scan_req.count;
         end else if (running_ff) begin
            chk_vld_ff <= rd_en;
            if (rd_en) begin
               issue_ff <= issue_ff + 1'b1;
            end
            // first hit in index order wins; stop on it
            if (hit_now) begin
               running_ff <= 1'b0;
               chk_vld_ff <= 1'b0;
               done_ff    <= 1'b1;
               hit_ff     <= 1'b1;
            end else if (!rd_en && !chk_vld_ff) begin
               running_ff <= 1'b0;
               done_ff    <= 1'b1;
               hit_ff     <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hit_now) begin
         color_ff <= rd_color_ff;
      end
   end

   assign scan_rsp.done  = done_ff;
   assign scan_rsp.hit   = hit_ff;
   assign scan_rsp.color = color_ff;

`ifndef ASSERT_OFF
   a_check_needs_run: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> running_ff)
      else $error("rect check pending while scan is stopped");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/ray_march_rect_hit.sv -----
// Load and start requests give no result. A step request moves the ray, then tests N
// rectangles (one per cycle through the shared hit unit, stopping at the first hit), then
// sends one or two results, each waiting until the output register is free.
// Throughput: one request at a time; req_tready is high only while the sequencer idles.
// Reset: synchronous, active high; clears the ray state and restores register defaults.
// Depends on rmrh_pkg and rmrh_rect_scan.
`timescale 1ns / 1ps
`default_nettype none

module ray_march_rect_hit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // rect_index, coord_x, coord_y, extent_x, extent_y, dir_x, dir_y, color,
   // max_length, show_path, reflect, zero fill
   input  wire logic [rmrh_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command
   input  wire logic [rmrh_pkg::CMD_W-1:0]          req_tuser,
   // result channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // pixel_x, pixel_y, pixel_color, ray_done, zero fill
   output logic [rmrh_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // drawn
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast,
   // configuration
   input  wire logic                                csr_we,
   input  wire logic [rmrh_pkg::REG_W-1:0]          csr_addr,
   input  wire logic [rmrh_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rmrh_pkg::*;

   // ---------------- request field unpack ----------------
   logic [IDX_IN_W-1:0]     in_rect_index;
   logic signed [POS_W-1:0] in_coord_x;
   logic signed [POS_W-1:0] in_coord_y;
   logic [EXT_W-1:0]        in_extent_x;
   logic [EXT_W-1:0]        in_extent_y;
   logic signed [DIR_W-1:0] in_dir_x;
   logic signed [DIR_W-1:0] in_dir_y;
   logic [COLOR_W-1:0]      in_color;
   logic [LEN_W-1:0]        in_max_length;
   logic                    in_show_path;
   logic                    in_reflect;
   rmrh_cmd_type            in_cmd;

   assign in_rect_index = req_tdata[3:0];
   assign in_coord_x    = req_tdata[19:4];
   assign in_coord_y    = req_tdata[35:20];
   assign in_extent_x   = req_tdata[50:36];
   assign in_extent_y   = req_tdata[65:51];
   assign in_dir_x      = req_tdata[73:66];
   assign in_dir_y      = req_tdata[81:74];
   assign in_color      = req_tdata[105:82];
   assign in_max_length = req_tdata[121:106];
   assign in_show_path  = req_tdata[122];
   assign in_reflect    = req_tdata[123];
   assign in_cmd        = rmrh_cmd_type'(req_tuser);

   // ---------------- registers ----------------
   rmrh_state_type          state_ff, state_in;
   logic [BOUND_W-1:0]      bound_x_ff, bound_y_ff;
   logic [COLOR_W-1:0]      path_color_ff;
   logic [COUNT_W-1:0]      rect_count_ff;

   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff;
   logic signed [DIR_W-1:0] step_x_ff, step_y_ff;
   logic [DIST_W-1:0]       dist_ff;
   logic [LEN_W-1:0]        len_ff;
   logic                    path_on_ff, bounce_on_ff, active_ff;

   logic                    hit_ff;
   logic [COLOR_W-1:0]      hit_color_ff;
   logic                    ray_end_ff;

   logic                    rsp_valid_ff;
   logic signed [PIX_W-1:0] rsp_px_ff, rsp_py_ff;
   logic [COLOR_W-1:0]      rsp_color_ff;
   logic                    rsp_drawn_ff, rsp_done_ff, rsp_last_ff;

   // ---------------- step arithmetic ----------------
   logic signed [POS_W:0]   sum_x, sum_y;
   logic signed [POS_W-1:0] pos_x_in, pos_y_in;
   logic signed [POS_W:0]   edge_x, edge_y;
   logic signed [DIR_W-1:0] flip_x, flip_y, step_x_in, step_y_in;
   logic [DIR_W-1:0]        abs_x, abs_y;
   logic [DIST_W:0]         dist_sum;
   logic [DIST_W-1:0]       dist_in;
   logic                    len_reached;

   assign sum_x    = (POS_W+1)'(pos_x_ff) + (POS_W+1)'(step_x_ff);
   assign sum_y    = (POS_W+1)'(pos_y_ff) + (POS_W+1)'(step_y_ff);
   assign pos_x_in = sat_pos(sum_x);
   assign pos_y_in = sat_pos(sum_y);

   // Canvas edges in position units; reflection tests the moved position.
   assign edge_x = signed'((POS_W+1)'({bound_x_ff, {FRAC_BITS{1'b0}}}));
   assign edge_y = signed'((POS_W+1)'({bound_y_ff, {FRAC_BITS{1'b0}}}));

   // High edge first, then low edge: both firing flips twice.
   assign flip_x    = (bounce_on_ff && ((POS_W+1)'(pos_x_in) >= edge_x)) ?
                      negate_dir(step_x_ff) : step_x_ff;
   assign step_x_in = (bounce_on_ff && (pos_x_in <= 0)) ? negate_dir(flip_x) : flip_x;
   assign flip_y    = (bounce_on_ff && ((POS_W+1)'(pos_y_in) >= edge_y)) ?
                      negate_dir(step_y_ff) : step_y_ff;
   assign step_y_in = (bounce_on_ff && (pos_y_in <= 0)) ? negate_dir(flip_y) : flip_y;

   assign abs_x    = step_x_ff[DIR_W-1] ? DIR_W'(-step_x_ff) : DIR_W'(step_x_ff);
   assign abs_y    = step_y_ff[DIR_W-1] ? DIR_W'(-step_y_ff) : DIR_W'(step_y_ff);
   assign dist_sum = {1'b0, dist_ff} + (DIST_W+1)'(abs_x) + (DIST_W+1)'(abs_y);
   assign dist_in  = dist_sum[DIST_W] ? {DIST_W{1'b1}} : dist_sum[DIST_W-1:0];

   assign len_reached = {{(LEN_W+FRAC_BITS){1'b0}}, dist_ff} >=
                        {{DIST_W{1'b0}}, len_ff, {FRAC_BITS{1'b0}}};

   // ---------------- rectangle table and scan ----------------
   rmrh_scan_req_type scan_req;
   rmrh_scan_rsp_type scan_rsp;
   rmrh_rect_type     load_rect;
   logic              load_en;
   logic              req_fire;
   logic              step_fire;

   assign req_fire  = req_tvalid && req_tready;
   assign step_fire = req_fire && (in_cmd == CMD_STEP) && active_ff;
   // drop loads addressed beyond the table
   assign load_en   = req_fire && (in_cmd == CMD_LOAD) && (int'(in_rect_index) < MAX_RECTS);

   assign load_rect.left  = in_coord_x;
   assign load_rect.top   = in_coord_y;
   assign load_rect.ext_x = in_extent_x;
   assign load_rect.ext_y = in_extent_y;

   assign scan_req.go    = step_fire;
   assign scan_req.count = (int'(rect_count_ff) > MAX_RECTS) ? SCAN_CNT_W'(MAX_RECTS) :
                                                               SCAN_CNT_W'(rect_count_ff);

   rmrh_rect_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .load_en    (load_en),
      .load_idx   (RECT_IDX_W'(in_rect_index)),
      .load_rect  (load_rect),
      .load_color (in_color),
      .scan_req   (scan_req),
      .pos_x      (pos_x_ff),
      .pos_y      (pos_y_ff),
      .scan_rsp   (scan_rsp)
   );

   // ---------------- sequencer: next state ----------------
   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (step_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_rsp.done) begin
               state_in = path_on_ff ? ST_PATH : ST_FINAL;
            end
         end
         ST_PATH: begin
            if (out_free) begin
               state_in = hit_ff ? ST_FINAL : ST_IDLE;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   logic               out_load;
   logic [COLOR_W-1:0] out_color;
   logic               out_drawn, out_done, out_last;

   always_comb begin
      req_tready = 1'b0;
      out_load   = 1'b0;
      out_color  = '0;
      out_drawn  = 1'b0;
      out_done   = 1'b0;
      out_last   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_SCAN: begin
         end
         ST_PATH: begin
            // path pixel goes ahead of a hit pixel
            out_load  = out_free;
            out_color = path_color_ff;
            out_drawn = 1'b1;
            out_done  = ray_end_ff && !hit_ff;
            out_last  = !hit_ff;
         end
         ST_FINAL: begin
            // hit pixel, or a blank marker when nothing was drawn
            out_load  = out_free;
            out_color = hit_ff ? hit_color_ff : '0;
            out_drawn = hit_ff;
            out_done  = ray_end_ff;
            out_last  = 1'b1;
         end
      endcase
   end

   // ---------------- state registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bound_x_ff    <= BOUND_X_RST;
         bound_y_ff    <= BOUND_Y_RST;
         path_color_ff <= PATH_COLOR_RST;
         rect_count_ff <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         step_x_ff     <= '0;
         step_y_ff     <= '0;
         dist_ff       <= '0;
         len_ff        <= '0;
         path_on_ff    <= 1'b0;
         bounce_on_ff  <= 1'b0;
         active_ff     <= 1'b0;
         hit_ff        <= 1'b0;
         ray_end_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (rmrh_reg_type'(csr_addr))
               REG_BOUND_X:    bound_x_ff    <= csr_wdata[BOUND_W-1:0];
               REG_BOUND_Y:    bound_y_ff    <= csr_wdata[BOUND_W-1:0];
               REG_PATH_COLOR: path_color_ff <= csr_wdata[COLOR_W-1:0];
               REG_RECT_COUNT: rect_count_ff <= csr_wdata[COUNT_W-1:0];
            endcase
         end

         if (req_fire && (in_cmd == CMD_START)) begin
            pos_x_ff     <= in_coord_x;
            pos_y_ff     <= in_coord_y;
            step_x_ff    <= in_dir_x;
            step_y_ff    <= in_dir_y;
            dist_ff      <= '0;
            len_ff       <= in_max_length;
            path_on_ff   <= in_show_path;
            bounce_on_ff <= in_reflect;
            // a zero length never starts
            active_ff    <= (in_max_length != '0);
         end

         // advance the ray and apply reflection
         if (step_fire) begin
            pos_x_ff  <= pos_x_in;
            pos_y_ff  <= pos_y_in;
            step_x_ff <= step_x_in;
            step_y_ff <= step_y_in;
            dist_ff   <= dist_in;
         end

         // scan finished: hold the verdict and end the ray on a hit or on length
         if ((state_ff == ST_SCAN) && scan_rsp.done) begin
            hit_ff     <= scan_rsp.hit;
            ray_end_ff <= scan_rsp.hit || len_reached;
            if (scan_rsp.hit || len_reached) begin
               active_ff <= 1'b0;
            end
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if ((state_ff == ST_SCAN) && scan_rsp.done) begin
         hit_color_ff <= scan_rsp.color;
      end
      if (out_load) begin
         rsp_px_ff    <= pixel_of(pos_x_ff);
         rsp_py_ff    <= pixel_of(pos_y_ff);
         rsp_color_ff <= out_color;
         rsp_drawn_ff <= out_drawn;
         rsp_done_ff  <= out_done;
         rsp_last_ff  <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_done_ff, rsp_color_ff, rsp_py_ff, rsp_px_ff};
   assign rsp_tuser  = rsp_drawn_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_scan_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_rsp.done |-> (state_ff == ST_SCAN))
      else $error("scan finished outside the scan state");

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> rsp_last_ff)
      else $error("ray end flagged on a result that is not the last of its step");

   a_first_is_path: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_drawn_ff && (rsp_color_ff == path_color_ff)))
      else $error("leading result of a step is not a path pixel");
`endif

endmodule

`default_nettype wire

// ----- bench/ray_march_rect_hit_tb.sv -----
// Self-checking bench for ray_march_rect_hit: rectangle loads, ray starts and steps checked
// beat by beat against a scoreboard that marches its own copy of the ray.
// Depends on rmrh_pkg and the ray_march_rect_hit RTL.
`timescale 1ns / 1ps

module ray_march_rect_hit_tb;
   import rmrh_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 220;
   localparam int MAX_REPORTS    = 40;

   // request word layout, lowest field last
   typedef struct packed {
      logic [3:0]         fill;
      logic               reflect;
      logic               show_path;
      logic [15:0]        max_length;
      logic [23:0]        color;
      logic signed [7:0]  dir_y;
      logic signed [7:0]  dir_x;
      logic [14:0]        extent_y;
      logic [14:0]        extent_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_x;
      logic [3:0]         rect_index;
   } ray_request_type;

   // result word layout, lowest field last
   typedef struct packed {
      logic [2:0]         fill;
      logic               ray_done;
      logic [23:0]        color;
      logic signed [9:0]  pixel_y;
      logic signed [9:0]  pixel_x;
   } pixel_word_type;

   typedef struct {
      pixel_word_type word;
      logic           drawn;
      logic           last;
   } pixel_beat_type;

   // Mirror of the ray marcher: registers, ray state and rectangle table, plus the
   // queue of pixels still owed by the block.
   class ray_pixel_scoreboard;
      logic [8:0]         bound_x, bound_y;
      logic [23:0]        path_rgb;
      logic [4:0]         rect_count;
      logic signed [15:0] pos_x, pos_y;
      logic signed [7:0]  step_x, step_y;
      logic [23:0]        travelled;
      logic [15:0]        length_limit;
      bit                 path_on, bounce_on, active;
      logic signed [15:0] rect_left[MAX_RECTS], rect_top[MAX_RECTS];
      logic [14:0]        rect_w[MAX_RECTS], rect_h[MAX_RECTS];
      logic [23:0]        rect_rgb[MAX_RECTS];
      pixel_beat_type     expected_pixels[$];
      int unsigned        mismatches, beats_seen;

      function new();
         bound_x = BOUND_X_RST;
         bound_y = BOUND_Y_RST;
         path_rgb = PATH_COLOR_RST;
         rect_count = '0;
         pos_x = '0; pos_y = '0; step_x = '0; step_y = '0;
         travelled = '0; length_limit = '0;
         path_on = 0; bounce_on = 0; active = 0;
         foreach (rect_left[i]) begin
            rect_left[i] = '0; rect_top[i] = '0;
            rect_w[i] = '0; rect_h[i] = '0; rect_rgb[i] = '0;
         end
         mismatches = 0;
         beats_seen = 0;
      endfunction

      function void write_reg(rmrh_reg_type idx, logic [23:0] v);
         case (idx)
            REG_BOUND_X:    bound_x = v[8:0];
            REG_BOUND_Y:    bound_y = v[8:0];
            REG_PATH_COLOR: path_rgb = v;
            REG_RECT_COUNT: rect_count = v[4:0];
            default: ;
         endcase
      endfunction

      function logic signed [9:0] to_pixel(logic signed [15:0] p);
         int q;
         q = int'(p) >>> FRAC_BITS;
         if (q > PIX_MAX) q = PIX_MAX;
         if (q < PIX_MIN) q = PIX_MIN;
         return 10'(q);
      endfunction

      function logic signed [15:0] clamp_pos(int v);
         if (v > 32767) return 16'sh7FFF;
         if (v < -32768) return 16'sh8000;
         return 16'(v);
      endfunction

      function logic signed [7:0] flip_dir(logic signed [7:0] v);
         if (v == -128) return 8'sd127;
         return -v;
      endfunction

      function int magnitude(logic signed [7:0] v);
         return (v < 0) ? -int'(v) : int'(v);
      endfunction

      function pixel_beat_type pixel_at(logic [23:0] rgb, logic drawn);
         pixel_beat_type b;
         b.word.fill = '0;
         b.word.ray_done = 1'b0;
         b.word.color = rgb;
         b.word.pixel_x = to_pixel(pos_x);
         b.word.pixel_y = to_pixel(pos_y);
         b.drawn = drawn;
         b.last = 1'b0;
         return b;
      endfunction

      // One move: advance, path pixel, edge bounce, first rectangle whose open
      // interior holds the new position, then the end-of-ray decision.
      function void march_step();
         pixel_beat_type beats[2];
         int px, py, bx, by, n, i, cnt;
         longint sum;
         bit hit, done;
         pos_x = clamp_pos(int'(pos_x) + int'(step_x));
         pos_y = clamp_pos(int'(pos_y) + int'(step_y));
         px = int'(pos_x);
         py = int'(pos_y);
         sum = longint'(travelled) + magnitude(step_x) + magnitude(step_y);
         travelled = (sum > 64'hFFFFFF) ? 24'hFFFFFF : 24'(sum);
         n = 0;
         hit = 0;
         if (path_on) begin
            beats[n] = pixel_at(path_rgb, 1'b1);
            n++;
         end
         if (bounce_on) begin
            bx = int'(bound_x) << FRAC_BITS;
            by = int'(bound_y) << FRAC_BITS;
            // high and low edge tests in turn: both firing cancels out
            if (px >= bx) step_x = flip_dir(step_x);
            if (px <= 0) step_x = flip_dir(step_x);
            if (py >= by) step_y = flip_dir(step_y);
            if (py <= 0) step_y = flip_dir(step_y);
         end
         cnt = (int'(rect_count) > MAX_RECTS) ? MAX_RECTS : int'(rect_count);
         for (i = 0; i < cnt && !hit; i++) begin
            if (px > int'(rect_left[i]) && px < int'(rect_left[i]) + int'(rect_w[i]) &&
                py > int'(rect_top[i]) && py < int'(rect_top[i]) + int'(rect_h[i])) begin
               beats[n] = pixel_at(rect_rgb[i], 1'b1);
               n++;
               hit = 1;
            end
         end
         done = hit || (longint'(travelled) >= (longint'(length_limit) << FRAC_BITS));
         if (n == 0) begin
            beats[0] = pixel_at(24'h0, 1'b0);
            n = 1;
         end
         beats[n-1].word.ray_done = done;
         beats[n-1].last = 1'b1;
         for (i = 0; i < n; i++) expected_pixels = {expected_pixels, beats[i]};
         if (done) active = 0;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, ray_request_type r);
         case (cmd)
            CMD_LOAD: begin
               rect_left[r.rect_index] = r.coord_x;
               rect_top[r.rect_index] = r.coord_y;
               rect_w[r.rect_index] = r.extent_x;
               rect_h[r.rect_index] = r.extent_y;
               rect_rgb[r.rect_index] = r.color;
            end
            CMD_START: begin
               pos_x = r.coord_x;
               pos_y = r.coord_y;
               step_x = r.dir_x;
               step_y = r.dir_y;
               travelled = '0;
               length_limit = r.max_length;
               path_on = r.show_path;
               bounce_on = r.reflect;
               active = (r.max_length != 0);
            end
            CMD_STEP: if (active) march_step();
            default: ;
         endcase
      endfunction

      task report(string field, logic [47:0] got, logic [47:0] want);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t ns pixel %0d: %s got %0h, expected %0h",
                     $time, beats_seen, field, got, want);
      endtask

      task check_pixel(pixel_word_type w, logic drawn, logic last);
         pixel_beat_type want;
         beats_seen++;
         if (expected_pixels.size() == 0) begin
            report("unexpected result", w, 48'h0);
            return;
         end
         want = expected_pixels.pop_front();
         if (w.pixel_x !== want.word.pixel_x) report("pixel_x", w.pixel_x, want.word.pixel_x);
         if (w.pixel_y !== want.word.pixel_y) report("pixel_y", w.pixel_y, want.word.pixel_y);
         if (w.color !== want.word.color) report("pixel_color", w.color, want.word.color);
         if (w.ray_done !== want.word.ray_done)
            report("ray_done", w.ray_done, want.word.ray_done);
         if (drawn !== want.drawn) report("drawn", drawn, want.drawn);
         if (last !== want.last) report("last", last, want.last);
      endtask

      task close_out();
         if (expected_pixels.size() != 0)
            report("pixels never delivered", 48'(expected_pixels.size()), 48'h0);
      endtask
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [REG_W-1:0]      csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ray_pixel_scoreboard sb;
   int burst_left = 1;
   bit sender_busy = 0;
   int ready_mode = 0;
   int ready_timer = 0;
   int idle_cycles = 0;

   ray_march_rect_hit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: hold a stall mode for a random stretch, then pick another. Modes are
   // always ready, coin flip, mostly stalled and strict alternation.
   always @(posedge clock) begin
      if (ready_timer == 0) begin
         ready_mode <= $urandom_range(0, 3);
         ready_timer <= $urandom_range(16, 120);
      end else begin
         ready_timer <= ready_timer - 1;
      end
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 5) == 0);
         default: rsp_tready <= ~rsp_tready;
      endcase
   end

   // Check every result beat accepted by the bench.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_pixel(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Watchdog: end the run when no request, result or register write moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one request and hold it until accepted; the scoreboard learns it at the
   // accepting edge. Bursts end with a gap so valid never drops
   // and rises in the same step.
   task automatic send_request(logic [CMD_W-1:0] cmd, ray_request_type r);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= r;
      sender_busy = 1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, r);
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         sender_busy = 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // Drop valid, wait for every owed pixel, then let a load or start still in flight
   // settle before the registers change.
   task automatic drain();
      if (sender_busy) begin
         req_tvalid <= 1'b0;
         sender_busy = 0;
      end
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(rmrh_reg_type idx, logic [23:0] v);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
   endtask

   task automatic program_regs(int bx, int by, int rgb, int cnt);
      write_csr(REG_BOUND_X, 24'(bx));
      write_csr(REG_BOUND_Y, 24'(by));
      write_csr(REG_PATH_COLOR, 24'(rgb));
      write_csr(REG_RECT_COUNT, 24'(cnt));
      csr_we <= 1'b0;
   endtask

   function automatic ray_request_type noise_fields();
      ray_request_type r;
      r = {$urandom, $urandom, $urandom, $urandom};
      r.fill = '0;
      return r;
   endfunction

   function automatic ray_request_type ray_start(int x, int y, int dx, int dy, int len,
                                                 bit path, bit bounce);
      ray_request_type r;
      r = '0;
      r.coord_x = 16'(x);
      r.coord_y = 16'(y);
      r.dir_x = 8'(dx);
      r.dir_y = 8'(dy);
      r.max_length = 16'(len);
      r.show_path = path;
      r.reflect = bounce;
      return r;
   endfunction

   function automatic ray_request_type rect_load(int idx, int x, int y, int w, int h,
                                                 int rgb);
      ray_request_type r;
      r = '0;
      r.rect_index = 4'(idx);
      r.coord_x = 16'(x);
      r.coord_y = 16'(y);
      r.extent_x = 15'(w);
      r.extent_y = 15'(h);
      r.color = 24'(rgb);
      return r;
   endfunction

   // Mostly rectangles on the canvas, now and then any geometry at all.
   function automatic ray_request_type random_rect();
      ray_request_type r;
      r = noise_fields();
      if ($urandom_range(0, 6) != 0) begin
         r.coord_x = 16'($urandom_range(0, 470 * 64));
         r.coord_y = 16'($urandom_range(0, 290 * 64));
         r.extent_x = 15'($urandom_range(64, 120 * 64));
         r.extent_y = 15'($urandom_range(64, 120 * 64));
      end
      return r;
   endfunction

   // Mostly rays from inside the canvas with short lengths; the rest raw noise.
   function automatic ray_request_type random_ray();
      ray_request_type r;
      r = noise_fields();
      if ($urandom_range(0, 99) < 85) begin
         r.coord_x = 16'($urandom_range(0, int'(sb.bound_x) * 64 + 63));
         r.coord_y = 16'($urandom_range(0, int'(sb.bound_y) * 64 + 63));
         r.dir_x = 8'(int'($urandom_range(0, 128)) - 64);
         r.dir_y = 8'(int'($urandom_range(0, 128)) - 64);
         r.max_length = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 48));
         if ($urandom_range(0, 29) == 0) r.max_length = '0;
      end
      return r;
   endfunction

   // Random traffic: with a ray running mostly step it, otherwise mostly start one.
   // Ignored requests (unused command, step with no ray) do not count toward the quota.
   task automatic random_phase(int quota);
      int counted, roll;
      logic [CMD_W-1:0] cmd;
      ray_request_type r;
      counted = 0;
      while (counted < quota) begin
         roll = $urandom_range(0, 99);
         if (sb.active) begin
            if (roll < 84) cmd = CMD_STEP;
            else if (roll < 90) cmd = CMD_LOAD;
            else if (roll < 96) cmd = CMD_START;
            else cmd = CMD_UNUSED;
         end else begin
            if (roll < 65) cmd = CMD_START;
            else if (roll < 80) cmd = CMD_LOAD;
            else if (roll < 92) cmd = CMD_STEP;
            else cmd = CMD_UNUSED;
         end
         case (cmd)
            CMD_LOAD:  r = random_rect();
            CMD_START: r = random_ray();
            default:   r = noise_fields();
         endcase
         if (cmd == CMD_LOAD || cmd == CMD_START || (cmd == CMD_STEP && sb.active)) counted++;
         send_request(cmd, r);
      end
   endtask

   // Directed cases at reset defaults and then with a zero-width canvas.
   task automatic directed_checks();
      // nothing running: step and the unused command are dropped
      send_request(CMD_STEP, noise_fields());
      send_request(CMD_UNUSED, noise_fields());
      // zero length start leaves the ray idle
      send_request(CMD_START, ray_start(0, 0, 64, 64, 0, 1, 1));
      send_request(CMD_STEP, noise_fields());
      // rect 1 encloses rect 0, so index order decides an overlap
      send_request(CMD_LOAD, rect_load(0, 6400, 6400, 3200, 3200, 'hFF0000));
      send_request(CMD_LOAD, rect_load(1, 5760, 5760, 6400, 6400, 'h00FF00));
      send_request(CMD_LOAD, rect_load(15, -32768, 32767, 'h7FFF, 'h7FFF, 'hFFFFFF));
      // saturate at both corners; pixels clamp to the pixel range
      send_request(CMD_START, ray_start(-32768, 32767, -128, 127, 1, 1, 0));
      send_request(CMD_STEP, noise_fields());
      // saturate then bounce; the most negative direction flips to the most positive
      send_request(CMD_START, ray_start(32700, 10, 127, -128, 65535, 0, 1));
      send_request(CMD_STEP, noise_fields());
      send_request(CMD_STEP, noise_fields());
      drain();
      program_regs(0, 300, 'h000000, 2);
      // zero right edge: landing on x == 0 fires both edge tests, which cancel
      send_request(CMD_START, ray_start(64, 1000, -64, 0, 3, 0, 1));
      repeat (3) send_request(CMD_STEP, noise_fields());
      // path pixel first, then the hit on rect 0
      send_request(CMD_START, ray_start(7680, 7680, 1, 0, 100, 1, 0));
      send_request(CMD_STEP, noise_fields());
      // still ray inside rect 1 only: hit without any distance
      send_request(CMD_START, ray_start(6080, 6080, 0, 0, 5, 0, 0));
      send_request(CMD_STEP, noise_fields());
      // land on rect 0's left edge: open interior misses it, rect 1 takes the hit
      send_request(CMD_START, ray_start(6336, 7000, 64, 0, 10, 0, 0));
      send_request(CMD_STEP, noise_fields());
   endtask

   initial begin
      int ph, i;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_checks();
      drain();
      program_regs(400, 300, 'h505050, 2);
      // fill the whole table before any phase puts more entries in use
      for (i = 0; i < MAX_RECTS; i++) send_request(CMD_LOAD, rect_load(i, 0, 0, 0, 0, 0) |
                                                   (random_rect() & ~ray_request_type'(4'hF)));

      for (ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: program_regs(400, 300, 'h505050, 4);
            1: program_regs(0, 0, $urandom_range(0, 'hFFFFFF), 16);
            2: program_regs(511, 511, 'hFFFFFF, 31);
            3: program_regs(511, 0, 'h000000, 17);
            4: program_regs($urandom_range(0, 511), $urandom_range(0, 511),
                            $urandom_range(0, 'hFFFFFF), 0);
            default: program_regs($urandom_range(0, 511), $urandom_range(0, 511),
                                  $urandom_range(0, 'hFFFFFF), $urandom_range(0, 31));
         endcase
         random_phase(PHASE_ITEMS);
      end

      drain();
      sb.close_out();
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
